// ===== hw/rtl/button_press_duration_classifier_unit_defines.svh =====
// Assertion macros for the button press duration classifier.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef BUTTON_PRESS_DURATION_CLASSIFIER_UNIT_DEFINES_SVH
`define BUTTON_PRESS_DURATION_CLASSIFIER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset
`define BPDC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Cause in one cycle implies effect in the next
`define BPDC_ASSERT_NEXT(label, clk, rst, cause, effect, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
      else $error(msg);
`else
`define BPDC_ASSERT(label, clk, rst, prop, msg)
`define BPDC_ASSERT_NEXT(label, clk, rst, cause, effect, msg)
`endif

`endif

// ===== hw/rtl/bpdc_pkg.sv =====
// Shared types and constants of the button press duration classifier.
// No dependencies.
`default_nettype none

package bpdc_pkg;

   localparam int TimeWidth  = 32;
   localparam int StageWidth = 3;
   localparam int ThrWidth   = 16;
   localparam int CsrIdxWidth = 3;

   typedef logic [StageWidth-1:0] stage_type;
   typedef logic [ThrWidth-1:0]   thr_type;
   typedef logic [TimeWidth-1:0]  time_type;

   // Stage codes
   localparam stage_type STAGE_IDLE  = 3'd0;
   localparam stage_type STAGE_SHORT = 3'd1;
   localparam stage_type STAGE_MID   = 3'd2;
   localparam stage_type STAGE_LONG  = 3'd3;
   localparam stage_type STAGE_WARN  = 3'd4;
   localparam stage_type STAGE_HOLD  = 3'd5;

   // Request commands
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   // Register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_INVERT_LEVEL = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_SHORT_MAX    = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_MID_MIN      = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_LONG_MIN     = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_WARN_MIN     = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_HOLD_MIN     = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CSR_HOLD_MAX     = 3'd6;

   // Register reset values
   localparam thr_type SHORT_MAX_RESET = 16'd500;
   localparam thr_type MID_MIN_RESET   = 16'd1000;
   localparam thr_type LONG_MIN_RESET  = 16'd2000;
   localparam thr_type WARN_MIN_RESET  = 16'd3000;
   localparam thr_type HOLD_MIN_RESET  = 16'd4000;
   localparam thr_type HOLD_MAX_RESET  = 16'd5000;

endpackage

`default_nettype wire

// ===== hw/rtl/button_press_duration_classifier_unit.sv =====
// Button press duration classifier: input register, classify logic, result register.
// Depends on bpdc_pkg and button_press_duration_classifier_unit_defines.svh.
// An accepted request waits in the input register until the result stage takes it.
// Throughput: one request per cycle while results are taken; a stalled result
// holds one request in the input register. Reset (synchronous, active high):
// default thresholds, stage idle, not pressed, press start zero, stages empty.
`default_nettype none
`include "button_press_duration_classifier_unit_defines.svh"

module button_press_duration_classifier_unit
   import bpdc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // configuration
   input  wire logic                   csr_we,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [ThrWidth-1:0]    csr_wdata,
   // requests
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic                   req_cmd,
   input  wire logic                   req_raw_level,
   input  wire logic [TimeWidth-1:0]   req_time_now,
   // results
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic [StageWidth-1:0]  rsp_stage
);

   // Configuration registers
   logic    invert_ff;
   thr_type short_max_ff, mid_min_ff, long_min_ff, warn_min_ff, hold_min_ff, hold_max_ff;

   // Input register
   logic     in_valid_ff;
   logic     cmd_ff;
   logic     raw_ff;
   time_type now_ff;

   // Classifier state; stage_ff doubles as the result register
   logic      out_valid_ff;
   logic      pressed_ff, pressed_in;
   time_type  start_ff, start_in;
   stage_type stage_ff, stage_in;

   logic      advance;
   logic      pressed;
   time_type  dur;

   // Write configuration registers; unknown indexes drop the write
   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff    <= 1'b0;
         short_max_ff <= SHORT_MAX_RESET;
         mid_min_ff   <= MID_MIN_RESET;
         long_min_ff  <= LONG_MIN_RESET;
         warn_min_ff  <= WARN_MIN_RESET;
         hold_min_ff  <= HOLD_MIN_RESET;
         hold_max_ff  <= HOLD_MAX_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INVERT_LEVEL: invert_ff    <= csr_wdata[0];
            CSR_SHORT_MAX:    short_max_ff <= csr_wdata;
            CSR_MID_MIN:      mid_min_ff   <= csr_wdata;
            CSR_LONG_MIN:     long_min_ff  <= csr_wdata;
            CSR_WARN_MIN:     warn_min_ff  <= csr_wdata;
            CSR_HOLD_MIN:     hold_min_ff  <= csr_wdata;
            CSR_HOLD_MAX:     hold_max_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance the input register into the result stage unless the result is stalled
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Capture a request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff <= req_cmd;
         raw_ff <= req_raw_level;
         now_ff <= req_time_now;
      end
   end

   // Classify: edge check, elapsed time and threshold compares in fixed order
   assign pressed = raw_ff ^ invert_ff;
   assign dur     = now_ff - start_ff;

   always_comb begin
      pressed_in = pressed_ff;
      start_in   = start_ff;
      stage_in   = stage_ff;
      if (cmd_ff == CMD_CLEAR) begin
         if (stage_ff == STAGE_SHORT || stage_ff == STAGE_HOLD) begin
            stage_in = STAGE_IDLE;
         end
      end else begin
         pressed_in = pressed;
         if (pressed && !pressed_ff) begin
            start_in = now_ff;
            stage_in = STAGE_IDLE;
         end else if (pressed && pressed_ff) begin
            priority if (dur > TimeWidth'(hold_max_ff)) begin
               stage_in = STAGE_IDLE;
            end else if (dur < TimeWidth'(mid_min_ff)) begin
               stage_in = STAGE_IDLE;
            end else if (dur < TimeWidth'(long_min_ff)) begin
               stage_in = STAGE_MID;
            end else if (dur < TimeWidth'(warn_min_ff)) begin
               stage_in = STAGE_LONG;
            end else begin
               stage_in = STAGE_WARN;
            end
         end else if (!pressed && pressed_ff) begin
            start_in = '0;
            priority if (dur < TimeWidth'(short_max_ff)) begin
               stage_in = STAGE_SHORT;
            end else if (dur >= TimeWidth'(hold_min_ff) && dur <= TimeWidth'(hold_max_ff)) begin
               stage_in = STAGE_HOLD;
            end else begin
               stage_in = STAGE_IDLE;
            end
         end
      end
   end

   // Update state and result on advance; drop the result once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pressed_ff   <= 1'b0;
         start_ff     <= '0;
         stage_ff     <= STAGE_IDLE;
      end else begin
         if (advance) begin
            out_valid_ff <= 1'b1;
            pressed_ff   <= pressed_in;
            start_ff     <= start_in;
            stage_ff     <= stage_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_stage = stage_ff;

   // Checks
   `BPDC_ASSERT(a_start_cleared, clock, reset, pressed_ff || (start_ff == '0),
      "press start not cleared while released")
   `BPDC_ASSERT_NEXT(a_clear_result, clock, reset, advance && (cmd_ff == CMD_CLEAR),
      (rsp_stage != STAGE_SHORT) && (rsp_stage != STAGE_HOLD), "clear left a pending event")
   `BPDC_ASSERT_NEXT(a_input_held, clock, reset, in_valid_ff && !advance,
      in_valid_ff && $stable(now_ff) && $stable(cmd_ff), "stalled request lost")

endmodule

`default_nettype wire

// ===== verif/press_stage_checker.sv =====
// Checker for the button press duration classifier: tracks register writes and
// requests, predicts the stage of every request and compares it with each result.
// Depends on bpdc_pkg for widths, stage codes and register indexes.
module press_stage_checker
   import bpdc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [ThrWidth-1:0]    csr_wdata,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   req_cmd,
   input  logic                   req_raw_level,
   input  logic [TimeWidth-1:0]   req_time_now,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [StageWidth-1:0]  rsp_stage,
   output int                     fail_count,
   output int                     pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Register copies
   logic    inv_cfg;
   thr_type short_max, mid_min, long_min, warn_min, hold_min, hold_max;

   // Button tracking state
   logic      btn_down;
   time_type  press_origin;
   stage_type stage_now;

   stage_type awaited_stages[$];

   // Apply one request to the tracking state and return the stage it leaves
   function automatic stage_type next_press_stage(logic cmd, logic lvl, time_type t);
      logic     down;
      time_type span;
      down = lvl ^ inv_cfg;
      span = t - press_origin;
      if (cmd == CMD_CLEAR) begin
         if (stage_now == STAGE_SHORT || stage_now == STAGE_HOLD)
            stage_now = STAGE_IDLE;
      end else begin
         if (down && !btn_down) begin
            press_origin = t;
            stage_now    = STAGE_IDLE;
         end else if (down && btn_down) begin
            // stuck check first, then the held thresholds in fixed order
            if (span > hold_max)
               stage_now = STAGE_IDLE;
            else if (span < mid_min)
               stage_now = STAGE_IDLE;
            else if (span < long_min)
               stage_now = STAGE_MID;
            else if (span < warn_min)
               stage_now = STAGE_LONG;
            else
               stage_now = STAGE_WARN;
         end else if (!down && btn_down) begin
            if (span < short_max)
               stage_now = STAGE_SHORT;
            else if (span >= hold_min && span <= hold_max)
               stage_now = STAGE_HOLD;
            else
               stage_now = STAGE_IDLE;
            press_origin = '0;
         end
         btn_down = down;
      end
      return stage_now;
   endfunction

   always @(posedge clock) begin
      int        errs;
      stage_type want;
      errs = 0;
      if (reset) begin
         inv_cfg      = 1'b0;
         short_max    = SHORT_MAX_RESET;
         mid_min      = MID_MIN_RESET;
         long_min     = LONG_MIN_RESET;
         warn_min     = WARN_MIN_RESET;
         hold_min     = HOLD_MIN_RESET;
         hold_max     = HOLD_MAX_RESET;
         btn_down     = 1'b0;
         press_origin = '0;
         stage_now    = STAGE_IDLE;
         awaited_stages.delete();
      end else begin
         // track register writes; unmapped indexes are dropped
         if (csr_we) begin
            case (csr_index)
               CSR_INVERT_LEVEL: inv_cfg   = csr_wdata[0];
               CSR_SHORT_MAX:    short_max = csr_wdata;
               CSR_MID_MIN:      mid_min   = csr_wdata;
               CSR_LONG_MIN:     long_min  = csr_wdata;
               CSR_WARN_MIN:     warn_min  = csr_wdata;
               CSR_HOLD_MIN:     hold_min  = csr_wdata;
               CSR_HOLD_MAX:     hold_max  = csr_wdata;
               default: ;
            endcase
         end
         // predict on every accepted request
         if (req_valid && req_ready)
            awaited_stages.push_back(next_press_stage(req_cmd, req_raw_level, req_time_now));
         // compare every accepted result with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (awaited_stages.size() == 0) begin
               $error("stage: result %0d arrived with no request outstanding", rsp_stage);
               errs++;
            end else begin
               want = awaited_stages.pop_front();
               if (rsp_stage !== want) begin
                  $error("stage mismatch: expected %0d, actual %0d", want, rsp_stage);
                  errs++;
               end
            end
         end
      end
      fail_count    <= fail_count + errs;
      pending_count <= awaited_stages.size();
   end

endmodule

// ===== verif/tb_button_press_duration_classifier_unit.sv =====
// Testbench top for the button press duration classifier: clock, reset, register
// settings, request and result stimulus, and the verdict.
// Depends on bpdc_pkg, the classifier unit and press_stage_checker.
module tb_button_press_duration_classifier_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import bpdc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam logic [CsrIdxWidth-1:0] CSR_UNMAPPED = 3'd7;

   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   csr_we        = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index     = '0;
   thr_type                csr_wdata     = '0;
   logic                   req_valid     = 1'b0;
   logic                   req_ready;
   logic                   req_cmd       = CMD_SAMPLE;
   logic                   req_raw_level = 1'b0;
   time_type               req_time_now  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready     = 1'b0;
   stage_type              rsp_stage;
   int                     fail_count;
   int                     pending_count;

   // Stimulus-side copies of the current settings
   logic    cur_invert = 1'b0;
   thr_type cur_short  = SHORT_MAX_RESET;
   thr_type cur_mid    = MID_MIN_RESET;
   thr_type cur_long   = LONG_MIN_RESET;
   thr_type cur_warn   = WARN_MIN_RESET;
   thr_type cur_hmin   = HOLD_MIN_RESET;
   thr_type cur_hmax   = HOLD_MAX_RESET;

   bit       steady        = 1'b0;
   int       requests_sent = 0;
   int       settings_run  = 1;
   int       cycle_count   = 0;
   time_type tnow          = 32'd100000;

   button_press_duration_classifier_unit i_dut (.*);
   press_stage_checker i_checker (.*);

   always #4 clock = ~clock;

   // Result side back-pressure
   always @(posedge clock) begin
      if (steady)
         rsp_ready <= 1'b1;
      else
         rsp_ready <= ($urandom_range(99) >= 37);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Offer one request, after a random idle gap unless steady; hold it until accepted
   task automatic send_request(input logic cmd, input logic lvl, input time_type t);
      if (!steady) begin
         while ($urandom_range(99) < 37) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_raw_level <= lvl;
      req_time_now  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic sample(input logic down, input time_type t);
      send_request(CMD_SAMPLE, down ^ cur_invert, t);
   endtask

   // Clear ignores level and time, so both are random
   task automatic clear_event();
      send_request(CMD_CLEAR, 1'($urandom_range(1)), time_type'($urandom()));
   endtask

   // Drop valid, let the outstanding count catch up with the last request,
   // wait for every outstanding result, then let the pipeline settle
   task automatic drain(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic put_csr(input logic [CsrIdxWidth-1:0] idx, input thr_type val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Load a full register set, plus a write to an unmapped index that must be dropped
   task automatic write_thresholds(input logic inv, input thr_type s, input thr_type m,
                                   input thr_type l, input thr_type w, input thr_type hmin,
                                   input thr_type hmax);
      thr_type inv_word;
      inv_word    = thr_type'($urandom());
      inv_word[0] = inv;
      drain(4);
      put_csr(CSR_INVERT_LEVEL, inv_word);
      put_csr(CSR_SHORT_MAX, s);
      put_csr(CSR_MID_MIN, m);
      put_csr(CSR_LONG_MIN, l);
      put_csr(CSR_WARN_MIN, w);
      put_csr(CSR_HOLD_MIN, hmin);
      put_csr(CSR_HOLD_MAX, hmax);
      put_csr(CSR_UNMAPPED, thr_type'($urandom()));
      csr_we     <= 1'b0;
      cur_invert = inv;
      cur_short  = s;
      cur_mid    = m;
      cur_long   = l;
      cur_warn   = w;
      cur_hmin   = hmin;
      cur_hmax   = hmax;
      settings_run++;
   endtask

   task automatic write_random_thresholds();
      write_thresholds(1'($urandom_range(1)),
                       thr_type'($urandom_range(6000)), thr_type'($urandom_range(6000)),
                       thr_type'($urandom_range(6000)), thr_type'($urandom_range(6000)),
                       thr_type'($urandom_range(6000)), thr_type'($urandom_range(6000)));
   endtask

   // Press length aimed at a threshold edge, or random
   function automatic time_type pick_span();
      case ($urandom_range(13))
         0:  return time_type'(cur_short) - 1;
         1:  return time_type'(cur_short);
         2:  return time_type'(cur_mid) - 1;
         3:  return time_type'(cur_mid);
         4:  return time_type'(cur_long);
         5:  return time_type'(cur_warn) - 1;
         6:  return time_type'(cur_warn);
         7:  return time_type'(cur_hmin) - 1;
         8:  return time_type'(cur_hmin);
         9:  return time_type'(cur_hmax);
         10: return time_type'(cur_hmax) + 1;
         11: return time_type'($urandom_range(int'(cur_hmax) + 16));
         12: return time_type'($urandom());
         default: return time_type'($urandom_range(200));
      endcase
   endfunction

   // One press: edge, a few held samples with the odd clear, release, maybe a clear
   task automatic press_episode();
      time_type t0;
      int       holds;
      t0    = tnow;
      holds = $urandom_range(5);
      sample(1'b1, t0);
      repeat (holds) begin
         if ($urandom_range(5) == 0)
            clear_event();
         else
            sample(1'b1, t0 + pick_span());
      end
      sample(1'b0, t0 + pick_span());
      if ($urandom_range(1))
         clear_event();
      tnow = t0 + time_type'($urandom_range(70000));
   endtask

   // Mostly well-formed presses, some noise, idle samples and stray clears
   task automatic run_random(input int count);
      int target;
      int pick;
      target = requests_sent + count;
      while (requests_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 5)
            tnow = time_type'($urandom());
         if (pick < 80)
            press_episode();
         else if (pick < 90)
            send_request(1'($urandom_range(1)), 1'($urandom_range(1)),
                         time_type'($urandom()));
         else if (pick < 95)
            sample(1'b0, tnow);
         else
            clear_event();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: idle sample, clear with nothing pending, every held stage
      sample(1'b0, 32'd100);
      clear_event();
      sample(1'b1, 32'd1000);
      sample(1'b1, 32'd1999);
      sample(1'b1, 32'd2000);
      sample(1'b1, 32'd3000);
      sample(1'b1, 32'd4000);
      // held exactly at the stuck limit, one past it, release past it
      sample(1'b1, 32'd6000);
      sample(1'b1, 32'd6001);
      sample(1'b0, 32'd6001);
      // short press then clear, hold press then clear
      sample(1'b1, 32'd10000);
      sample(1'b0, 32'd10499);
      clear_event();
      sample(1'b1, 32'd20000);
      sample(1'b0, 32'd24000);
      clear_event();
      // release between the short and hold windows
      sample(1'b1, 32'd30000);
      sample(1'b0, 32'd30500);
      // timestamp wrap while held; clear leaves mid alone
      sample(1'b1, 32'hFFFF_FF00);
      sample(1'b1, 32'h0000_0300);
      clear_event();
      sample(1'b0, 32'h0000_0400);
      // timestamp before the press start reads as a very long press
      sample(1'b1, 32'hFFFF_FFFF);
      sample(1'b1, 32'hFFFF_FFFE);
      sample(1'b0, 32'h0000_0000);

      run_random(280);

      // Inverted level, tight ordered thresholds
      write_thresholds(1'b1, 16'd5, 16'd10, 16'd20, 16'd30, 16'd40, 16'd50);
      run_random(250);

      // All thresholds at zero
      write_thresholds(1'b0, '0, '0, '0, '0, '0, '0);
      run_random(150);

      // All thresholds at the top
      write_thresholds(1'b1, '1, '1, '1, '1, '1, '1);
      run_random(150);

      // Unordered thresholds, with a full pause of the sender half way
      write_random_thresholds();
      run_random(150);
      drain(4);
      run_random(100);

      // No idling on either side
      write_random_thresholds();
      steady = 1'b1;
      run_random(200);
      steady = 1'b0;

      drain(8);
      $display("Run summary: %0d requests over %0d register settings", requests_sent,
               settings_run);
      $display("covering idle, held, released, cleared, wrapped and random requests");
      if (fail_count == 0 && pending_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
